@@ rtl/isl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg
// Shared constants, action and status codes, and interface structs of the
// indexed sequence list.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int WORD_W   = 32;
    localparam int ACT_W    = 3;
    localparam int ST_W     = 2;

    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ERASE      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DUMP       = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_INDEX = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] word;
        logic              word_valid;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ rtl/indexed_sequence_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_list
// Ordered list of up to 16 signed 32-bit words held in a synchronous RAM.
// ----------------------------------------------------------------------------
// One transaction in carries one action: push back, push front, pop front,
// pop back, insert at an index, erase at an index, or dump. Every action
// returns one transaction out with a status and the new count, except a dump
// of a non-empty list, which returns one transaction per stored word in
// order with last set on the final one. Full, empty and bad-index requests
// are refused with a status and leave the list untouched; action code seven
// is a no-op. The block works on one action at a time and takes the next
// once the current one has handed off its last result to the output
// register. Cost is set by the single RAM port pair, which moves one
// entry per cycle: each moved word is read and then written one slot over,
// so insert and erase take longer the further the index lies below the
// count, while a refused or no-op action moves nothing; dump reads and
// hands out one stored word at a time. Output stalls add to the time.
// Entries are not cleared at reset; only entries below the count are ever
// read.
// ----------------------------------------------------------------------------
module indexed_sequence_list (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic        [isl_pkg::ACT_W-1:0]   i_action,
    input  logic        [isl_pkg::CNT_W-1:0]   i_position,
    input  logic signed [isl_pkg::WORD_W-1:0]  i_word_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic        [isl_pkg::ST_W-1:0]    o_status,
    output logic        [isl_pkg::CNT_W-1:0]   o_count_out,
    output logic signed [isl_pkg::WORD_W-1:0]  o_word_out,
    output logic                               o_word_valid,
    output logic                               o_last
);

    isl_pkg::t_ram_req              w_ram;
    logic [isl_pkg::WORD_W-1:0]     w_rdata;
    logic                           w_res_push;
    isl_pkg::t_result               w_res;
    logic                           w_res_free;

    // output register state
    logic                           r_out_valid;
    isl_pkg::t_result               r_out;

    // entry store
    isl_ram #(
        .DEPTH (isl_pkg::CAPACITY),
        .WIDTH (isl_pkg::WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // action sequencer
    isl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_position (i_position),
        .i_word_in  (i_word_in),
        .o_ram      (w_ram),
        .i_rdata    (w_rdata),
        .i_res_free (w_res_free),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    // the output register can take a new result when empty or draining
    assign w_res_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload while a transaction waits for the consumer
    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_count_out  = r_out.count;
    assign o_word_out   = r_out.word;
    assign o_word_valid = r_out.word_valid;
    assign o_last       = r_out.last;

endmodule

@@ rtl/isl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module isl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/isl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ctrl
// Sequencer: decodes an action, moves entries through the RAM one per cycle
// for insert and erase, walks the RAM for dump, and hands results out.
// ----------------------------------------------------------------------------
module isl_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [isl_pkg::ACT_W-1:0]    i_action,
    input  logic [isl_pkg::CNT_W-1:0]    i_position,
    input  logic [isl_pkg::WORD_W-1:0]   i_word_in,
    output isl_pkg::t_ram_req            o_ram,
    input  logic [isl_pkg::WORD_W-1:0]   i_rdata,
    input  logic                         i_res_free,
    output logic                         o_res_push,
    output isl_pkg::t_result             o_res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_ERA      = 3'd2;
    localparam logic [2:0] S_DUMP_RD  = 3'd3;
    localparam logic [2:0] S_DUMP_OUT = 3'd4;
    localparam logic [2:0] S_RES      = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [isl_pkg::CNT_W-1:0]    r_count, n_count;
    logic [isl_pkg::ADDR_W-1:0]   r_cur, n_cur;
    logic [isl_pkg::ADDR_W-1:0]   r_pos, n_pos;
    logic [isl_pkg::WORD_W-1:0]   r_word, n_word;
    logic                         r_wp, n_wp;
    logic [isl_pkg::ADDR_W-1:0]   r_wa, n_wa;
    logic [isl_pkg::ST_W-1:0]     r_status, n_status;

    logic                         w_full;
    logic                         w_empty;
    logic [isl_pkg::CNT_W-1:0]    w_cur_ext;
    logic                         w_ins_more;
    logic                         w_era_more;
    logic                         w_dump_last;

    assign w_full      = (r_count >= isl_pkg::CNT_W'(isl_pkg::CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_cur_ext   = isl_pkg::CNT_W'(r_cur);
    assign w_ins_more  = (r_cur != r_pos);
    assign w_era_more  = ((w_cur_ext + isl_pkg::CNT_W'(1)) < r_count);
    assign w_dump_last = ((w_cur_ext + isl_pkg::CNT_W'(1)) == r_count);
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_word     = r_word;
        n_wp       = 1'b0;
        n_wa       = r_wa;
        n_status   = r_status;
        o_ram      = '0;
        o_res_push = 1'b0;
        o_res      = '0;

        // drain a pending move: the word read last cycle lands one slot over
        if (r_wp) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_wa;
            o_ram.wdata = i_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word   = i_word_in;
                    n_status = isl_pkg::ST_OK;
                    n_state  = S_RES;
                    case (i_action) inside
                        isl_pkg::ACT_PUSH_BACK, isl_pkg::ACT_PUSH_FRONT,
                        isl_pkg::ACT_INSERT: begin
                            n_cur = r_count[isl_pkg::ADDR_W-1:0];
                            if (i_action == isl_pkg::ACT_PUSH_BACK) begin
                                n_pos = r_count[isl_pkg::ADDR_W-1:0];
                            end else if (i_action == isl_pkg::ACT_PUSH_FRONT) begin
                                n_pos = '0;
                            end else begin
                                n_pos = i_position[isl_pkg::ADDR_W-1:0];
                            end
                            if (w_full) begin
                                n_status = isl_pkg::ST_FULL;
                            end else if (i_action == isl_pkg::ACT_INSERT &&
                                         i_position > r_count) begin
                                n_status = isl_pkg::ST_INDEX;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        isl_pkg::ACT_POP_FRONT, isl_pkg::ACT_POP_BACK,
                        isl_pkg::ACT_ERASE: begin
                            if (i_action == isl_pkg::ACT_POP_FRONT) begin
                                n_cur = '0;
                            end else if (i_action == isl_pkg::ACT_POP_BACK) begin
                                n_cur = isl_pkg::ADDR_W'(r_count - isl_pkg::CNT_W'(1));
                            end else begin
                                n_cur = i_position[isl_pkg::ADDR_W-1:0];
                            end
                            if (w_empty) begin
                                n_status = isl_pkg::ST_EMPTY;
                            end else if (i_action == isl_pkg::ACT_ERASE &&
                                         i_position >= r_count) begin
                                n_status = isl_pkg::ST_INDEX;
                            end else begin
                                n_state = S_ERA;
                            end
                        end
                        isl_pkg::ACT_DUMP: begin
                            n_cur = '0;
                            if (w_empty) begin
                                n_status = isl_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_status = isl_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // open a gap: walk down from the tail, each word moves up one slot
            S_INS: begin
                if (w_ins_more) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_cur - isl_pkg::ADDR_W'(1);
                    n_wp        = 1'b1;
                    n_wa        = r_cur;
                    n_cur       = r_cur - isl_pkg::ADDR_W'(1);
                end else if (!r_wp) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = r_word;
                    n_count     = r_count + isl_pkg::CNT_W'(1);
                    n_state     = S_RES;
                end
            end

            // close a gap: walk up from the target, each word moves down one slot
            S_ERA: begin
                if (w_era_more) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_cur + isl_pkg::ADDR_W'(1);
                    n_wp        = 1'b1;
                    n_wa        = r_cur;
                    n_cur       = r_cur + isl_pkg::ADDR_W'(1);
                end else if (!r_wp) begin
                    n_count = r_count - isl_pkg::CNT_W'(1);
                    n_state = S_RES;
                end
            end

            S_DUMP_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_cur;
                n_state     = S_DUMP_OUT;
            end

            // read data holds until the output stage takes it
            S_DUMP_OUT: begin
                if (i_res_free) begin
                    o_res_push       = 1'b1;
                    o_res.status     = isl_pkg::ST_OK;
                    o_res.count      = r_count;
                    o_res.word       = i_rdata;
                    o_res.word_valid = 1'b1;
                    o_res.last       = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = r_cur + isl_pkg::ADDR_W'(1);
                        n_state = S_DUMP_RD;
                    end
                end
            end

            S_RES: begin
                if (i_res_free) begin
                    o_res_push   = 1'b1;
                    o_res.status = r_status;
                    o_res.count  = r_count;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wp    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wp    <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_wa     <= n_wa;
        r_status <= n_status;
    end

endmodule

@@ rtl/isl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_checker
// Port-level checks of the indexed sequence list, bound to the top level.
// ----------------------------------------------------------------------------
module isl_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic        [isl_pkg::ST_W-1:0]    o_status,
    input  logic        [isl_pkg::CNT_W-1:0]   o_count_out,
    input  logic signed [isl_pkg::WORD_W-1:0]  o_word_out,
    input  logic                               o_word_valid,
    input  logic                               o_last
);

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_word_out) &&
        $stable(o_count_out) && $stable(o_last))
        else $error("output transaction changed while stalled");

    // a result without a word is always the only, final result of its action
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_valid |-> o_last && o_word_out == '0)
        else $error("result without word not final or word not zero");

    // words only come with an ok status
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid |-> o_status == isl_pkg::ST_OK)
        else $error("dump word carries a failing status");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count_out <= isl_pkg::CNT_W'(isl_pkg::CAPACITY))
        else $error("count beyond capacity");

    // no new action is taken while a dump is still delivering words
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid && !o_last |-> !o_in_ready)
        else $error("action accepted in the middle of a dump");

endmodule

bind indexed_sequence_list isl_checker u_isl_checker (.*);
